// File: src/gae_pkg.sv
// Shared types, codes and value-width helpers for the grouped aggregate engine.
// No dependencies.
package gae_pkg;

    localparam int unsigned VAL_W = 64;
    localparam int unsigned GID_W = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 3;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_SUM      = 3'd0,
        KIND_MIN      = 3'd1,
        KIND_MAX      = 3'd2,
        KIND_AVG      = 3'd3,
        KIND_COUNT    = 3'd4,
        KIND_COUNT_ALL = 3'd5,
        KIND_RSVD6    = 3'd6,
        KIND_RSVD7    = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        CFG_KIND   = 2'd0,
        CFG_SIGNED = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] acc;
        logic             pres;
        logic [VAL_W-1:0] cnt;
    } t_entry;

    function automatic logic [VAL_W-1:0] width_mask(input logic [1:0] wcode);
        logic [VAL_W-1:0] m;
        case (wcode)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    // Sign- or zero-extend the low width bits to 64 bits.
    function automatic logic [VAL_W-1:0] widen(input logic [VAL_W-1:0] x,
                                               input logic sgn,
                                               input logic [1:0] wcode);
        logic [VAL_W-1:0] m;
        logic [VAL_W-1:0] top;
        logic [VAL_W-1:0] r;
        m   = width_mask(wcode);
        top = (m >> 1) + 64'd1;
        r   = x & m;
        if (sgn && ((r & top) != '0)) begin
            r = r | ~m;
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] x,
                                                   input logic sgn,
                                                   input logic [1:0] wcode);
        logic [VAL_W-1:0] w;
        w = widen(x, sgn, wcode);
        return sgn ? {~w[VAL_W-1], w[VAL_W-2:0]} : w;
    endfunction

endpackage

// File: src/gae_in_if.sv
// Input channel of the grouped aggregate engine: valid/ready plus one update,
// read-out, clear or no-op word. Depends on gae_pkg.
interface gae_in_if import gae_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [GID_W-1:0] group_id;
    logic [VAL_W-1:0] value;
    logic             is_null;

    modport source (output valid, mode, group_id, value, is_null, input ready);
    modport sink (input valid, mode, group_id, value, is_null, output ready);
endinterface

// File: src/gae_out_if.sv
// Result channel of the grouped aggregate engine: valid/ready plus one result word.
// Depends on gae_pkg.
interface gae_out_if import gae_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] result_value;
    logic             result_null;

    modport source (output valid, result_value, result_null, input ready);
    modport sink (input valid, result_value, result_null, output ready);
endinterface

// File: src/grouped_aggregate_engine_top.sv
// Grouped aggregation engine top: configuration registers, entry read-modify-write
// sequencer and result register. Depends on gae_pkg, gae_in_if, gae_out_if,
// gae_store and gae_div.
//
//   channel   dir   word
//   i_in      in    mode, group_id, value, is_null
//   o_out     out   result_value, result_null (read-out only)
//   i_cfg_*   in    register index, data
//
// One item at a time: update and clear accept with the memory read, then modify and
// write back; plain read-out then loads the result word, and avg read-out first runs
// the shift-subtract divider and waits for its done flag.
// After reset a sweep clears all GROUPS entries, one a cycle; i_in.ready stays low.
// A result waits in the output register; the next item is taken meanwhile, and a
// read-out stalls only if its result is ready before the previous one was taken.
module grouped_aggregate_engine_top import gae_pkg::*; #(
    parameter int unsigned GROUPS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gae_in_if.sink                i_in,
    gae_out_if.source             o_out
);

    localparam int unsigned AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    t_state           r_state, n_state;
    t_kind            r_kind;
    logic             r_signed;
    logic [1:0]       r_wcode;

    t_mode            r_mode;
    logic [AW-1:0]    r_addr;
    logic             r_inside;
    logic [VAL_W-1:0] r_value;
    logic             r_null;
    logic             r_neg;
    logic [VAL_W-1:0] r_res_val;
    logic             r_res_null;
    logic             r_ovalid;
    logic [VAL_W-1:0] r_oval;
    logic             r_onull;

    logic             store_busy;
    logic             accept;
    logic             in_range;
    t_entry           rd_data;
    t_entry           ent;
    t_entry           wr_data;
    logic             wr_en;
    logic [VAL_W-1:0] mask;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] s;
    logic             s_neg;
    logic [VAL_W-1:0] mag;
    logic             div_start;
    logic             div_done;
    logic [VAL_W-1:0] div_quo;
    logic [VAL_W-1:0] quo_fix;
    logic [VAL_W-1:0] rd_val;
    logic             rd_null;
    logic             load_out;

    assign i_in.ready = (r_state == ST_IDLE) && !store_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign in_range   = ({{(32-GID_W){1'b0}}, i_in.group_id} < 32'(GROUPS));

    gae_store #(.GROUPS(GROUPS), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(i_in.group_id)),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .o_busy    (store_busy)
    );

    gae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag),
        .i_den   (ent.cnt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_SUM;
            r_signed <= 1'b1;
            r_wcode  <= 2'd3;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KIND:   r_kind   <= t_kind'(i_cfg_data);
                CFG_SIGNED: r_signed <= i_cfg_data[0];
                CFG_WIDTH:  r_wcode  <= i_cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    // modify the entry read for the held word
    always_comb begin
        mask    = width_mask(r_wcode);
        v       = r_value & mask;
        ent     = r_inside ? rd_data : '0;
        wr_data = ent;
        wr_en   = 1'b0;
        s       = widen(ent.acc, r_signed, r_wcode);
        s_neg   = r_signed && s[VAL_W-1];
        mag     = s_neg ? (VAL_W'(0) - s) : s;
        quo_fix = (r_neg ? (VAL_W'(0) - div_quo) : div_quo) & mask;
        rd_val  = '0;
        rd_null = 1'b1;

        if (r_state == ST_RMW && r_inside) begin
            if (r_mode == MODE_CLEAR) begin
                wr_en   = 1'b1;
                wr_data = '0;
            end else if (r_mode == MODE_UPDATE && (!r_null || r_kind == KIND_COUNT_ALL)) begin
                case (r_kind)
                    KIND_SUM: begin
                        wr_en        = 1'b1;
                        wr_data.acc  = (ent.acc + v) & mask;
                        wr_data.pres = 1'b1;
                    end
                    KIND_MIN: begin
                        wr_en        = 1'b1;
                        if (!ent.pres || order_key(v, r_signed, r_wcode)
                                         < order_key(ent.acc, r_signed, r_wcode)) begin
                            wr_data.acc = v;
                        end
                        wr_data.pres = 1'b1;
                    end
                    KIND_MAX: begin
                        wr_en        = 1'b1;
                        if (!ent.pres || order_key(ent.acc, r_signed, r_wcode)
                                         < order_key(v, r_signed, r_wcode)) begin
                            wr_data.acc = v;
                        end
                        wr_data.pres = 1'b1;
                    end
                    KIND_AVG: begin
                        wr_en       = 1'b1;
                        wr_data.acc = (ent.acc + v) & mask;
                        wr_data.cnt = ent.cnt + 64'd1;
                    end
                    KIND_COUNT, KIND_COUNT_ALL: begin
                        wr_en       = 1'b1;
                        wr_data.cnt = ent.cnt + 64'd1;
                    end
                    default: ;
                endcase
            end
        end

        case (r_kind)
            KIND_SUM, KIND_MIN, KIND_MAX: begin
                rd_val  = ent.pres ? (ent.acc & mask) : '0;
                rd_null = !ent.pres;
            end
            KIND_COUNT, KIND_COUNT_ALL: begin
                rd_val  = ent.cnt;
                rd_null = 1'b0;
            end
            default: ;
        endcase
    end

    assign div_start = (r_state == ST_RMW) && (r_mode == MODE_READ)
                       && (r_kind == KIND_AVG) && (ent.cnt != '0);
    assign load_out  = (r_state == ST_FIN) && (!r_ovalid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_RMW;
            ST_RMW: begin
                if (r_mode != MODE_READ) begin
                    n_state = ST_IDLE;
                end else if (div_start) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV:  if (div_done) n_state = ST_FIN;
            ST_FIN:  if (load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload: hold the word, the pending result and the output word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= t_mode'(i_in.mode);
            r_addr   <= AW'(i_in.group_id);
            r_inside <= in_range;
            r_value  <= i_in.value;
            r_null   <= i_in.is_null;
        end
        if (r_state == ST_RMW) begin
            r_neg      <= s_neg;
            r_res_val  <= rd_val;
            r_res_null <= rd_null;
        end
        if (r_state == ST_DIV && div_done) begin
            r_res_val  <= quo_fix;
            r_res_null <= 1'b0;
        end
        if (load_out) begin
            r_oval  <= r_res_val;
            r_onull <= r_res_null;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.result_value = r_oval;
    assign o_out.result_null  = r_onull;

endmodule

// File: src/gae_store.sv
// Group entry memory: one read port with registered data, one write port, and a
// clearing sweep after reset. Depends on gae_pkg.
module gae_store import gae_pkg::*; #(
    parameter int unsigned GROUPS = 1024,
    parameter int unsigned AW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    output logic          o_busy
);

    t_entry        r_mem [GROUPS];
    t_entry        r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(GROUPS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

// File: src/gae_div.sv
// Restoring unsigned 64/64 divider, one quotient bit per cycle.
// Depends on gae_pkg.
module gae_div import gae_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_num,
    input  logic [VAL_W-1:0] i_den,
    output logic             o_done,
    output logic [VAL_W-1:0] o_quo
);

    localparam int unsigned CW = $clog2(VAL_W + 1);

    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_quo;
    logic [VAL_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [VAL_W:0]   rem_sh;
    logic [VAL_W:0]   diff;

    assign rem_sh = {r_rem, r_quo[VAL_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(VAL_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            // keep the partial remainder when the trial subtract goes negative
            if (!diff[VAL_W]) begin
                r_rem <= diff[VAL_W-1:0];
                r_quo <= {r_quo[VAL_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[VAL_W-1:0];
                r_quo <= {r_quo[VAL_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: verif/testbench.sv
// Self-checking bench for grouped_aggregate_engine_top: directed rows, each kind,
// then random updates/read-outs/clears under several configurations and idle patterns.
// Depends on gae_pkg, gae_in_if, gae_out_if and the engine RTL.
`timescale 1ns / 1ps
module testbench;
    import gae_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             is_null;
    } t_result;

    typedef struct {
        t_mode            mode;
        logic [GID_W-1:0] gid;
        logic [VAL_W-1:0] value;
        logic             is_null;
        logic             known;
        t_result          want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gae_in_if  in_ch ();
    gae_out_if out_ch ();

    grouped_aggregate_engine_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    // predictor state
    logic [VAL_W-1:0] sum_tab [1024];
    logic             seen_tab [1024];
    logic [VAL_W-1:0] rows_tab [1024];
    t_kind            cur_kind;
    logic             cur_sgn;
    logic [1:0]       cur_wcode;

    t_result pending_results[$];
    int      errors;
    int      cycles;
    int      send_idle_pct;
    int      recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report(input string what, input logic [VAL_W-1:0] got,
                          input logic [VAL_W-1:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [VAL_W-1:0] mask_of();
        case (cur_wcode)
            2'd0:    return 64'hFF;
            2'd1:    return 64'hFFFF;
            2'd2:    return 64'hFFFF_FFFF;
            default: return '1;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] extend(input logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] m;
        logic [VAL_W-1:0] r;
        m = mask_of();
        r = x & m;
        if (cur_sgn && (r & ~(m >> 1)) != 0) r = r | ~m;
        return r;
    endfunction

    function automatic logic below(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        if (cur_sgn) return $signed(extend(a)) < $signed(extend(b));
        return extend(a) < extend(b);
    endfunction

    function automatic logic [VAL_W-1:0] mean_of(input logic [VAL_W-1:0] s,
                                                 input logic [VAL_W-1:0] n);
        logic [VAL_W-1:0] w;
        logic [VAL_W-1:0] q;
        w = extend(s);
        if (cur_sgn && w[VAL_W-1]) begin
            q = (-w) / n;
            return (-q) & mask_of();
        end
        return (w / n) & mask_of();
    endfunction

    // fold one word into the table; return 1 with the result for read-outs
    function automatic logic aggregate(input t_mode md, input logic [GID_W-1:0] g,
                                       input logic [VAL_W-1:0] raw, input logic nul,
                                       output t_result res);
        logic [VAL_W-1:0] v;
        v = raw & mask_of();
        res = '0;
        case (md)
            MODE_UPDATE: begin
                if (!nul || cur_kind == KIND_COUNT_ALL) begin
                    case (cur_kind)
                        KIND_SUM: begin
                            sum_tab[g] = (sum_tab[g] + v) & mask_of();
                            seen_tab[g] = 1'b1;
                        end
                        KIND_MIN: begin
                            if (!seen_tab[g] || below(v, sum_tab[g])) sum_tab[g] = v;
                            seen_tab[g] = 1'b1;
                        end
                        KIND_MAX: begin
                            if (!seen_tab[g] || below(sum_tab[g], v)) sum_tab[g] = v;
                            seen_tab[g] = 1'b1;
                        end
                        KIND_AVG: begin
                            sum_tab[g] = (sum_tab[g] + v) & mask_of();
                            rows_tab[g]++;
                        end
                        KIND_COUNT, KIND_COUNT_ALL: rows_tab[g]++;
                        default: ;
                    endcase
                end
                return 1'b0;
            end
            MODE_CLEAR: begin
                sum_tab[g] = '0;
                seen_tab[g] = 1'b0;
                rows_tab[g] = '0;
                return 1'b0;
            end
            MODE_READ: begin
                case (cur_kind)
                    KIND_SUM, KIND_MIN, KIND_MAX: begin
                        res.value = seen_tab[g] ? (sum_tab[g] & mask_of()) : '0;
                        res.is_null = !seen_tab[g];
                    end
                    KIND_AVG: begin
                        res.value = rows_tab[g] != 0 ? mean_of(sum_tab[g], rows_tab[g]) : '0;
                        res.is_null = rows_tab[g] == 0;
                    end
                    KIND_COUNT, KIND_COUNT_ALL: res.value = rows_tab[g];
                    default: res.is_null = 1'b1;
                endcase
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // valid stays up after an accept so the next word can follow at once
    task automatic send(input t_mode md, input logic [GID_W-1:0] g,
                        input logic [VAL_W-1:0] v, input logic nul,
                        input logic known, input t_result want);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= md;
        in_ch.group_id <= g;
        in_ch.value <= v;
        in_ch.is_null <= nul;
        do @(posedge i_clk); while (!in_ch.ready);
        if (aggregate(md, g, v, nul, res)) begin
            if (known && res.value != want.value)
                report("directed row value", res.value, want.value);
            if (known && res.is_null != want.is_null)
                report("directed row null", VAL_W'(res.is_null), VAL_W'(want.is_null));
            pending_results.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.value = out_ch.result_value;
            got.is_null = out_ch.result_null;
            if (pending_results.size() == 0) begin
                report("unexpected result", got.value, '0);
            end else begin
                exp_r = pending_results.pop_front();
                if (got.value != exp_r.value) report("result_value", got.value, exp_r.value);
                if (got.is_null != exp_r.is_null)
                    report("result_null", VAL_W'(got.is_null), VAL_W'(exp_r.is_null));
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // drop valid, hold until every result is back, then let an update finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic configure(input t_kind k, input logic sg, input logic [1:0] wc);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_KIND;
        i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_idx <= CFG_SIGNED;
        i_cfg_data <= {2'b0, sg};
        @(posedge i_clk);
        i_cfg_idx <= CFG_WIDTH;
        i_cfg_data <= {1'b0, wc};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_kind = k;
        cur_sgn = sg;
        cur_wcode = wc;
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(5))
            0:       return '1;
            1:       return 64'h8000_0000_0000_0000;
            2:       return VAL_W'($urandom_range(3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [GID_W-1:0] g;
        int r;
        for (int i = 0; i < count; i++) begin
            // mostly a few hot groups so entries collect several rows
            g = ($urandom_range(9) < 8) ? GID_W'($urandom_range(7))
                                        : GID_W'($urandom_range(1023));
            r = $urandom_range(99);
            if (r < 60) send(MODE_UPDATE, g, rand_value(), $urandom_range(9) == 0, 1'b0, '0);
            else if (r < 88)
                send(MODE_READ, g, rand_value(), 1'($urandom_range(1)), 1'b0, '0);
            else if (r < 96)
                send(MODE_CLEAR, g, rand_value(), 1'($urandom_range(1)), 1'b0, '0);
            else send(MODE_NONE, g, rand_value(), 1'($urandom_range(1)), 1'b0, '0);
        end
    endtask

    t_row rows[$];

    initial begin
        t_row rw;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_KIND;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_UPDATE;
        in_ch.group_id = '0;
        in_ch.value = '0;
        in_ch.is_null = 1'b0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 1024; i++) begin
            sum_tab[i] = '0;
            seen_tab[i] = 1'b0;
            rows_tab[i] = '0;
        end
        cur_kind = KIND_SUM;
        cur_sgn = 1'b1;
        cur_wcode = 2'd3;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: mode, gid, value, null, known, expected
        rows = '{
            '{MODE_READ,   10'd0,    64'd0, 1'b0, 1'b1, '{64'd0, 1'b1}},
            '{MODE_READ,   10'd1023, 64'd0, 1'b0, 1'b1, '{64'd0, 1'b1}},
            '{MODE_UPDATE, 10'd1023, '1,    1'b0, 1'b0, '0},
            '{MODE_UPDATE, 10'd1023, 64'd1, 1'b0, 1'b0, '0},
            '{MODE_READ,   10'd1023, 64'd0, 1'b0, 1'b1, '{64'd0, 1'b0}},
            '{MODE_UPDATE, 10'd5,    64'd7, 1'b1, 1'b0, '0},
            '{MODE_READ,   10'd5,    64'd0, 1'b0, 1'b1, '{64'd0, 1'b1}},
            '{MODE_UPDATE, 10'd5,    64'h8000_0000_0000_0000, 1'b0, 1'b0, '0},
            '{MODE_NONE,   10'd5,    64'd3, 1'b0, 1'b0, '0},
            '{MODE_READ,   10'd5,    64'd0, 1'b1, 1'b1, '{64'h8000_0000_0000_0000, 1'b0}},
            '{MODE_CLEAR,  10'd5,    '1,    1'b1, 1'b0, '0},
            '{MODE_READ,   10'd5,    64'd0, 1'b0, 1'b1, '{64'd0, 1'b1}}
        };
        foreach (rows[i]) begin
            rw = rows[i];
            send(rw.mode, rw.gid, rw.value, rw.is_null, rw.known, rw.want);
        end

        // each kind, reserved codes too, signedness from bit 0 and width code from bits 1:0
        for (int k = 0; k < 8; k++) begin
            configure(t_kind'(k), k[0], k[1:0]);
            for (int g = 0; g < 3; g++) begin
                send(MODE_UPDATE, GID_W'(g), '1, 1'b0, 1'b0, '0);
                send(MODE_UPDATE, GID_W'(g), 64'h80, 1'b0, 1'b0, '0);
                send(MODE_UPDATE, GID_W'(g), 64'd1, 1'b1, 1'b0, '0);
                send(MODE_READ, GID_W'(g), '0, 1'b0, 1'b0, '0);
            end
        end

        send_idle_pct = 24;
        recv_idle_pct = 82;
        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                send_idle_pct = 82;
                recv_idle_pct = 24;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure(t_kind'($urandom_range(p == 11 ? 7 : 5)), 1'($urandom_range(1)),
                      2'($urandom_range(3)));
            random_phase(p == 6 ? 25 : 50);
            if (p == 6) drain();
        end

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: grouped_aggregate_engine_top.f
src/gae_pkg.sv
src/gae_in_if.sv
src/gae_out_if.sv
src/gae_store.sv
src/gae_div.sv
src/grouped_aggregate_engine_top.sv
verif/testbench.sv
